// ----- sv/lz2rld_pkg.sv -----
`timescale 1ns / 1ps

package lz2rld_pkg;

    // Default history size; the decoder addresses it modulo its depth.
    localparam int LZ2_HISTORY_DEPTH = 65536;

    // Field widths of the item and result beats.
    localparam int KIND_W     = 2;
    localparam int BYTE_W     = 8;
    localparam int STATUS_W   = 2;
    localparam int ERR_W      = 3;
    localparam int COUNT_W    = 17;
    localparam int CONSUMED_W = 32;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_BYTE    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_TICK    = 2'd1;
    localparam logic [KIND_W-1:0] KIND_END     = 2'd2;
    localparam logic [KIND_W-1:0] KIND_RESTART = 2'd3;

    // Stream status codes.
    localparam logic [STATUS_W-1:0] ST_DECODING = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DONE     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ERROR    = 2'd2;

    // Error codes.
    localparam logic [ERR_W-1:0] ERR_NONE        = 3'd0;
    localparam logic [ERR_W-1:0] ERR_EMPTY       = 3'd1;
    localparam logic [ERR_W-1:0] ERR_TRUNCATED   = 3'd2;
    localparam logic [ERR_W-1:0] ERR_TOO_LARGE   = 3'd3;
    localparam logic [ERR_W-1:0] ERR_BAD_REPEAT  = 3'd4;
    localparam logic [ERR_W-1:0] ERR_UNSUPPORTED = 3'd5;

    // Commands of a header byte.
    localparam logic [2:0] CMD_COPY     = 3'd0;
    localparam logic [2:0] CMD_FILL     = 3'd1;
    localparam logic [2:0] CMD_WORD     = 3'd2;
    localparam logic [2:0] CMD_INC      = 3'd3;
    localparam logic [2:0] CMD_REPEAT   = 3'd4;
    localparam logic [2:0] CMD_ESCAPE   = 3'd7;

    // Decoder phases.
    localparam logic [2:0] PH_HEADER = 3'd0;
    localparam logic [2:0] PH_LONG   = 3'd1;
    localparam logic [2:0] PH_ARG1   = 3'd2;
    localparam logic [2:0] PH_ARG2   = 3'd3;
    localparam logic [2:0] PH_COPY   = 3'd4;
    localparam logic [2:0] PH_EMIT   = 3'd5;

    localparam logic [BYTE_W-1:0]  END_MARK  = 8'hFF;
    localparam logic [COUNT_W-1:0] LIMIT_MAX = 17'h10000;

    // One result beat.
    typedef struct packed {
        logic                  out_valid;
        logic [BYTE_W-1:0]     out_byte;
        logic                  want_byte;
        logic [STATUS_W-1:0]   status;
        logic [ERR_W-1:0]      error_code;
        logic [COUNT_W-1:0]    produced_count;
        logic [CONSUMED_W-1:0] consumed_count;
    } t_result;

endpackage

// ----- sv/lz2rld_in_if.sv -----
`timescale 1ns / 1ps

interface lz2rld_in_if;
    import lz2rld_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, kind, data_byte, input ready);
    modport sink   (input valid, kind, data_byte, output ready);
endinterface

// ----- sv/lz2rld_out_if.sv -----
`timescale 1ns / 1ps

interface lz2rld_out_if;
    import lz2rld_pkg::*;

    logic                  valid;
    logic                  ready;
    logic                  out_valid;
    logic [BYTE_W-1:0]     out_byte;
    logic                  want_byte;
    logic [STATUS_W-1:0]   status;
    logic [ERR_W-1:0]      error_code;
    logic [COUNT_W-1:0]    produced_count;
    logic [CONSUMED_W-1:0] consumed_count;

    modport source (output valid, out_valid, out_byte, want_byte, status, error_code,
                    produced_count, consumed_count, input ready);
    modport sink   (input valid, out_valid, out_byte, want_byte, status, error_code,
                    produced_count, consumed_count, output ready);
endinterface

// ----- sv/lz2_run_length_decompressor_core.sv -----
`timescale 1ns / 1ps

// LZ2 stream decoder. Every input beat (compressed byte, output tick, end of input or
// restart) yields exactly one result beat, and a new beat is taken every clock cycle
// as long as the result side keeps up. An accepted beat updates the decoder state and
// issues the read of the history memory into the read stage; the read stage then
// selects the byte (from the memory read data, or forwarded from the byte written
// while that read was issued, when a repeat reads the entry just produced), writes it
// back to history and passes the result on to the output register. The history
// memory has one write and one registered read port and HISTORY_DEPTH entries, which
// must be a power of two; it is not cleared, since a repeat only reads entries already
// written. The user must write max_output only while the block is idle; the block
// itself does not enforce this. Values 0 and above 65536 of max_output act as 65536.
module lz2_run_length_decompressor_core #(
    parameter int HISTORY_DEPTH = lz2rld_pkg::LZ2_HISTORY_DEPTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lz2rld_pkg::COUNT_W-1:0]    i_cfg_data,
    lz2rld_in_if.sink                         i_in,
    lz2rld_out_if.source                      o_out
);
    import lz2rld_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);

    // Configuration and architectural decoder state.
    logic [COUNT_W-1:0]    r_max_output;
    logic [2:0]            r_phase,   n_phase;
    logic [2:0]            r_cmd,     n_cmd;
    logic [10:0]           r_rem,     n_rem;
    logic [7:0]            r_first,   n_first;
    logic [7:0]            r_second,  n_second;
    logic [15:0]           r_src,     n_src;
    logic [9:0]            r_run,     n_run;
    logic [COUNT_W-1:0]    r_wp,      n_wp;
    logic [CONSUMED_W-1:0] r_cons,    n_cons;
    logic [STATUS_W-1:0]   r_status,  n_status;
    logic [ERR_W-1:0]      r_err,     n_err;
    logic                  r_end_pend, n_end_pend;

    // Read stage and output register.
    logic                  r_p_valid;
    t_result               r_p_res;
    logic                  r_p_we;
    logic                  r_p_mem;
    logic [AW-1:0]         r_p_addr;
    logic                  r_fwd_hit;
    logic [7:0]            r_fwd_byte;
    logic [7:0]            r_rd_data;
    logic                  r_o_valid;
    t_result               r_o_res;

    logic [7:0]            r_hist [HISTORY_DEPTH];

    logic                  in_ready;
    logic                  in_fire;
    logic                  p_move;
    logic                  mem_we;
    logic [7:0]            s_byte;
    t_result               s_res;
    logic [16:0]           rd_sum;
    logic [AW-1:0]         rd_addr;
    logic [COUNT_W-1:0]    limit;
    logic                  put;
    logic                  put_mem;
    logic [7:0]            put_val;
    logic                  bc_go;
    logic [2:0]            bc_cmd;
    logic [10:0]           bc_cnt;
    logic [17:0]           bc_end;
    logic [CONSUMED_W-1:0] cons_inc;
    logic [15:0]           rep_addr;
    t_result               n_res;

    // Handshake: the read stage advances when the output register is free or drains.
    assign p_move   = r_p_valid && (!r_o_valid || o_out.ready);
    assign in_ready = !r_p_valid || p_move;
    assign in_fire  = i_in.valid && in_ready;
    assign mem_we   = p_move && r_p_we;
    assign i_in.ready = in_ready;

    // Effective output limit.
    assign limit = (r_max_output == '0 || r_max_output > LIMIT_MAX) ? LIMIT_MAX
                                                                     : r_max_output;

    // Repeat source address and saturating consumed count.
    assign rd_sum   = {1'b0, r_src} + {7'b0, r_run};
    assign rd_addr  = rd_sum[AW-1:0];
    assign cons_inc = (r_cons == '1) ? r_cons : r_cons + 32'd1;
    assign rep_addr = {r_first, i_in.data_byte};

    // Decoder next state for the beat being accepted.
    always_comb begin
        n_phase    = r_phase;
        n_cmd      = r_cmd;
        n_rem      = r_rem;
        n_first    = r_first;
        n_second   = r_second;
        n_src      = r_src;
        n_run      = r_run;
        n_wp       = r_wp;
        n_cons     = r_cons;
        n_status   = r_status;
        n_err      = r_err;
        n_end_pend = r_end_pend;
        put        = 1'b0;
        put_mem    = 1'b0;
        put_val    = 8'd0;
        bc_go      = 1'b0;
        bc_cmd     = r_cmd;
        bc_cnt     = r_rem;
        bc_end     = 18'd0;

        if (i_in.kind == KIND_RESTART) begin
            n_phase    = PH_HEADER;
            n_cmd      = 3'd0;
            n_rem      = 11'd0;
            n_first    = 8'd0;
            n_second   = 8'd0;
            n_src      = 16'd0;
            n_run      = 10'd0;
            n_wp       = '0;
            n_cons     = '0;
            n_status   = ST_DECODING;
            n_err      = ERR_NONE;
            n_end_pend = 1'b0;
        end else if (r_status == ST_DECODING) begin
            unique case (i_in.kind)
                KIND_BYTE: begin
                    priority case (r_phase)
                        PH_COPY: begin
                            n_cons  = cons_inc;
                            put     = 1'b1;
                            put_val = i_in.data_byte;
                        end
                        PH_HEADER: begin
                            n_cons = cons_inc;
                            if (i_in.data_byte == END_MARK) begin
                                n_status = ST_DONE;
                            end else if (i_in.data_byte[7:5] == CMD_ESCAPE) begin
                                n_cmd   = i_in.data_byte[4:2];
                                n_rem   = {1'b0, i_in.data_byte[1:0], 8'd0};
                                n_phase = PH_LONG;
                            end else begin
                                bc_go  = 1'b1;
                                bc_cmd = i_in.data_byte[7:5];
                                bc_cnt = {6'd0, i_in.data_byte[4:0]} + 11'd1;
                            end
                        end
                        PH_LONG: begin
                            n_cons = cons_inc;
                            bc_go  = 1'b1;
                            bc_cmd = r_cmd;
                            bc_cnt = {1'b0, r_rem[9:8], i_in.data_byte} + 11'd1;
                        end
                        PH_ARG1: begin
                            n_cons  = cons_inc;
                            n_first = i_in.data_byte;
                            n_phase = (r_cmd == CMD_FILL || r_cmd == CMD_INC) ? PH_EMIT
                                                                             : PH_ARG2;
                        end
                        PH_ARG2: begin
                            n_cons   = cons_inc;
                            n_second = i_in.data_byte;
                            if (r_cmd == CMD_REPEAT) begin
                                if ({1'b0, rep_addr} >= r_wp) begin
                                    n_status = ST_ERROR;
                                    n_err    = ERR_BAD_REPEAT;
                                end else begin
                                    n_src   = rep_addr;
                                    n_phase = PH_EMIT;
                                end
                            end else begin
                                n_phase = PH_EMIT;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
                KIND_TICK: begin
                    if (r_phase == PH_EMIT) begin
                        put = 1'b1;
                        priority case (r_cmd)
                            CMD_FILL: put_val = r_first;
                            CMD_WORD: put_val = r_run[0] ? r_second : r_first;
                            CMD_INC:  put_val = r_first + r_run[7:0];
                            default:  put_mem = 1'b1;
                        endcase
                    end
                end
                KIND_END: begin
                    priority case (r_phase)
                        PH_HEADER: begin
                            if (r_cons == '0) begin
                                n_status = ST_ERROR;
                                n_err    = ERR_EMPTY;
                            end else begin
                                n_status = ST_DONE;
                            end
                        end
                        PH_EMIT: n_end_pend = 1'b1;
                        default: begin
                            n_status = ST_ERROR;
                            n_err    = ERR_TRUNCATED;
                        end
                    endcase
                end
                default: begin
                end
            endcase
        end

        // Start of a command: limit check first, then command dispatch.
        if (bc_go) begin
            n_cmd  = bc_cmd;
            n_rem  = bc_cnt;
            bc_end = {1'b0, r_wp} + {7'd0, bc_cnt};
            if (bc_end > {1'b0, limit}) begin
                n_status = ST_ERROR;
                n_err    = ERR_TOO_LARGE;
            end else begin
                n_run = 10'd0;
                if (bc_cmd == CMD_COPY) begin
                    n_phase = PH_COPY;
                end else if (bc_cmd <= CMD_REPEAT) begin
                    n_phase = PH_ARG1;
                end else begin
                    n_status = ST_ERROR;
                    n_err    = ERR_UNSUPPORTED;
                end
            end
        end

        // One byte produced: advance the run.
        if (put) begin
            n_wp  = r_wp + 17'd1;
            n_run = r_run + 10'd1;
            n_rem = r_rem - 11'd1;
            if (r_rem == 11'd1) begin
                n_phase = PH_HEADER;
                if (r_end_pend) begin
                    n_status = ST_DONE;
                end
            end
        end
    end

    // Snapshot of the result fields after this beat.
    always_comb begin
        n_res.out_valid      = put;
        n_res.out_byte       = put_val;
        n_res.want_byte      = (n_status == ST_DECODING) && (n_phase != PH_EMIT);
        n_res.status         = n_status;
        n_res.error_code     = n_err;
        n_res.produced_count = n_wp;
        n_res.consumed_count = n_cons;
    end

    // Byte of the read stage: memory, forwarded write, or computed value.
    assign s_byte = r_p_mem ? (r_fwd_hit ? r_fwd_byte : r_rd_data) : r_p_res.out_byte;

    // Result beat of the read stage with its final byte.
    always_comb begin
        s_res          = r_p_res;
        s_res.out_byte = s_byte;
    end

    // Control and decoder state registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_output <= LIMIT_MAX;
            r_phase      <= PH_HEADER;
            r_cmd        <= 3'd0;
            r_rem        <= 11'd0;
            r_first      <= 8'd0;
            r_second     <= 8'd0;
            r_src        <= 16'd0;
            r_run        <= 10'd0;
            r_wp         <= '0;
            r_cons       <= '0;
            r_status     <= ST_DECODING;
            r_err        <= ERR_NONE;
            r_end_pend   <= 1'b0;
            r_p_valid    <= 1'b0;
            r_o_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_output <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase    <= n_phase;
                r_cmd      <= n_cmd;
                r_rem      <= n_rem;
                r_first    <= n_first;
                r_second   <= n_second;
                r_src      <= n_src;
                r_run      <= n_run;
                r_wp       <= n_wp;
                r_cons     <= n_cons;
                r_status   <= n_status;
                r_err      <= n_err;
                r_end_pend <= n_end_pend;
                r_p_valid  <= 1'b1;
            end else if (p_move) begin
                r_p_valid <= 1'b0;
            end
            if (p_move) begin
                r_o_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_p_res    <= n_res;
            r_p_we     <= put;
            r_p_mem    <= put_mem;
            r_p_addr   <= r_wp[AW-1:0];
            r_fwd_hit  <= mem_we && (r_p_addr == rd_addr);
            r_fwd_byte <= s_byte;
        end
        if (p_move) begin
            r_o_res <= s_res;
        end
    end

    // History memory: write from the read stage, registered read on accept.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_hist[r_p_addr] <= s_byte;
        end
        if (in_fire) begin
            r_rd_data <= r_hist[rd_addr];
        end
    end

    // Result port.
    assign o_out.valid          = r_o_valid;
    assign o_out.out_valid      = r_o_res.out_valid;
    assign o_out.out_byte       = r_o_res.out_byte;
    assign o_out.want_byte      = r_o_res.want_byte;
    assign o_out.status         = r_o_res.status;
    assign o_out.error_code     = r_o_res.error_code;
    assign o_out.produced_count = r_o_res.produced_count;
    assign o_out.consumed_count = r_o_res.consumed_count;

endmodule

// ----- sv/lz2rld_checker.sv -----
`timescale 1ns / 1ps

module lz2rld_checker (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_out_valid,
    input logic                              i_out_ready,
    input logic                              i_res_valid,
    input logic [lz2rld_pkg::BYTE_W-1:0]     i_res_byte,
    input logic                              i_want_byte,
    input logic [lz2rld_pkg::STATUS_W-1:0]   i_status,
    input logic [lz2rld_pkg::ERR_W-1:0]      i_error_code
);
    import lz2rld_pkg::*;

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_res_byte)
            && $stable(i_status) && $stable(i_error_code))
        else $error("result beat changed while stalled");

    // A stopped stream never asks for more compressed bytes.
    a_stop_no_want: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_status != ST_DECODING |-> !i_want_byte)
        else $error("want_byte set after the stream stopped");

    // A beat without a decoded byte carries a zero byte.
    a_empty_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_res_valid |-> i_res_byte == '0)
        else $error("nonzero byte on a beat without output");

    // An error code is reported exactly when the stream stopped on error.
    a_err_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> ((i_error_code != ERR_NONE) == (i_status == ST_ERROR)))
        else $error("error code and status disagree");

    // No result beat comes out right after reset.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result beat right after reset");

endmodule

bind lz2_run_length_decompressor_core lz2rld_checker u_lz2rld_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_res_valid  (o_out.out_valid),
    .i_res_byte   (o_out.out_byte),
    .i_want_byte  (o_out.want_byte),
    .i_status     (o_out.status),
    .i_error_code (o_out.error_code)
);
